// ----- rtl/adckp_pkg.sv -----
`timescale 1ns / 1ps

package adckp_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int BTN_W       = 3;
    localparam int SAMPLE_W    = 8;
    localparam int FLAG_W      = 5;
    localparam int COUNT_W     = 3;
    localparam int CFG_W       = 6;

    typedef logic [FLAG_W-1:0]      flags_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [NUM_BUTTONS-1:0] bmask_t;

    // flag bit positions
    localparam int FLAG_LOCKED     = 0;
    localparam int FLAG_PRESSED    = 1;
    localparam int FLAG_RELEASED   = 2;
    localparam int FLAG_PRESS_EV   = 3;
    localparam int FLAG_RELEASE_EV = 4;

    localparam flags_t FLAGS_RESET = flags_t'(1 << FLAG_RELEASED);

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic {
        CFG_SCAN_ENABLE = 1'b0,
        CFG_DEBOUNCE    = 1'b1
    } cfg_idx_t;

    localparam bmask_t SCAN_RESET  = '0;
    localparam count_t LIMIT_RESET = count_t'(6);

    // open windows; button 0 has no lower bound
    localparam logic [SAMPLE_W-1:0] WIN_LOW [NUM_BUTTONS] =
        '{8'd0, 8'd25, 8'd65, 8'd115, 8'd165, 8'd200};
    localparam logic [SAMPLE_W-1:0] WIN_HIGH [NUM_BUTTONS] =
        '{8'd25, 8'd65, 8'd115, 8'd160, 8'd195, 8'd220};

    function automatic logic win_hit(input int unsigned b, input logic [SAMPLE_W-1:0] s);
        logic hit;
        hit = (s < WIN_HIGH[b]) && ((b == 0) || (s > WIN_LOW[b]));
        return hit;
    endfunction

endpackage

// ----- rtl/adc_ladder_keypad_debouncer.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   func, adc_sample, button, flag_mask
// out      source     out_valid/out_stall pressed_mask, released_mask,
//                                         press_event_mask, release_event_mask,
//                                         locked_mask
// cfg      sink       cfg_we              cfg_index, cfg_data
//
// One item per cycle sustained while out_stall does not hold the result register;
// each item passes the input register, then the flag and counter update and result register in one pass.
// in_stall rises only while the input register is full and the result register
// is held by out_stall.
// Reset clears all flags to released, counters to zero, scan mask to zero, limit to 6.

module adc_ladder_keypad_debouncer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         func,
    input  logic [adckp_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [adckp_pkg::BTN_W-1:0]        button,
    input  logic [adckp_pkg::FLAG_W-1:0]       flag_mask,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [adckp_pkg::NUM_BUTTONS-1:0]  pressed_mask,
    output logic [adckp_pkg::NUM_BUTTONS-1:0]  released_mask,
    output logic [adckp_pkg::NUM_BUTTONS-1:0]  press_event_mask,
    output logic [adckp_pkg::NUM_BUTTONS-1:0]  release_event_mask,
    output logic [adckp_pkg::NUM_BUTTONS-1:0]  locked_mask,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [adckp_pkg::CFG_W-1:0]        cfg_data
);

    localparam int NB = adckp_pkg::NUM_BUTTONS;

    adckp_pkg::bmask_t  scan_reg;
    adckp_pkg::count_t  limit_reg;

    logic                               s1_valid_reg;
    logic [1:0]                         func_reg;
    logic [adckp_pkg::SAMPLE_W-1:0]     sample_reg;
    logic [adckp_pkg::BTN_W-1:0]        button_reg;
    adckp_pkg::flags_t                  fmask_reg;

    adckp_pkg::flags_t  flags_reg  [NB];
    adckp_pkg::flags_t  flags_next [NB];
    adckp_pkg::count_t  count_reg  [NB];
    adckp_pkg::count_t  count_next [NB];

    logic               out_valid_reg;
    adckp_pkg::bmask_t  pm_reg, rm_reg, pe_reg, re_reg, lk_reg;
    adckp_pkg::bmask_t  pm_next, rm_next, pe_next, re_next, lk_next;
    adckp_pkg::bmask_t  pm_cur, rm_cur, pe_cur, re_cur, lk_cur;

    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // state update for the item in the input register
    always_comb
    begin
        adckp_pkg::flags_t f;
        logic              hit;
        f   = '0;
        hit = 1'b0;
        for (int b = 0; b < NB; b++)
        begin
            flags_next[b] = flags_reg[b];
            count_next[b] = count_reg[b];
        end
        case (func_reg)
            adckp_pkg::FUNC_TICK:
            begin
                for (int b = 0; b < NB; b++)
                begin
                    f   = flags_reg[b];
                    hit = adckp_pkg::win_hit(b, sample_reg);
                    if (scan_reg[b] && !f[adckp_pkg::FLAG_LOCKED])
                    begin
                        if (!hit)
                        begin
                            if (count_reg[b] != '0)
                                count_next[b] = count_reg[b] - 1'b1;
                            else if (f[adckp_pkg::FLAG_PRESSED])
                            begin
                                f[adckp_pkg::FLAG_RELEASE_EV] = 1'b1;
                                f[adckp_pkg::FLAG_RELEASED]   = 1'b1;
                                f[adckp_pkg::FLAG_PRESSED]    = 1'b0;
                            end
                        end
                        else
                        begin
                            if (count_reg[b] < limit_reg)
                                count_next[b] = count_reg[b] + 1'b1;
                            else if (f[adckp_pkg::FLAG_RELEASED])
                            begin
                                f[adckp_pkg::FLAG_PRESS_EV] = 1'b1;
                                f[adckp_pkg::FLAG_PRESSED]  = 1'b1;
                                f[adckp_pkg::FLAG_RELEASED] = 1'b0;
                            end
                        end
                    end
                    flags_next[b] = f;
                end
            end
            adckp_pkg::FUNC_SET:
            begin
                for (int b = 0; b < NB; b++)
                    if (button_reg == adckp_pkg::BTN_W'(b))
                        flags_next[b] = flags_reg[b] | fmask_reg;
            end
            adckp_pkg::FUNC_CLEAR:
            begin
                for (int b = 0; b < NB; b++)
                    if (button_reg == adckp_pkg::BTN_W'(b))
                        flags_next[b] = flags_reg[b] & ~fmask_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            pm_next[b] = flags_next[b][adckp_pkg::FLAG_PRESSED];
            rm_next[b] = flags_next[b][adckp_pkg::FLAG_RELEASED];
            pe_next[b] = flags_next[b][adckp_pkg::FLAG_PRESS_EV];
            re_next[b] = flags_next[b][adckp_pkg::FLAG_RELEASE_EV];
            lk_next[b] = flags_next[b][adckp_pkg::FLAG_LOCKED];
            pm_cur[b]  = flags_reg[b][adckp_pkg::FLAG_PRESSED];
            rm_cur[b]  = flags_reg[b][adckp_pkg::FLAG_RELEASED];
            pe_cur[b]  = flags_reg[b][adckp_pkg::FLAG_PRESS_EV];
            re_cur[b]  = flags_reg[b][adckp_pkg::FLAG_RELEASE_EV];
            lk_cur[b]  = flags_reg[b][adckp_pkg::FLAG_LOCKED];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= adckp_pkg::SCAN_RESET;
            limit_reg <= adckp_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adckp_pkg::CFG_SCAN_ENABLE: scan_reg  <= cfg_data[NB-1:0];
                adckp_pkg::CFG_DEBOUNCE:    limit_reg <= cfg_data[adckp_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg   <= func;
            sample_reg <= adc_sample;
            button_reg <= button;
            fmask_reg  <= flag_mask;
        end
    end

    // button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                flags_reg[b] <= adckp_pkg::FLAGS_RESET;
                count_reg[b] <= '0;
            end
        end
        else if (advance)
        begin
            for (int b = 0; b < NB; b++)
            begin
                flags_reg[b] <= flags_next[b];
                count_reg[b] <= count_next[b];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pm_reg <= pm_next;
            rm_reg <= rm_next;
            pe_reg <= pe_next;
            re_reg <= re_next;
            lk_reg <= lk_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pressed_mask       = pm_reg;
    assign released_mask      = rm_reg;
    assign press_event_mask   = pe_reg;
    assign release_event_mask = re_reg;
    assign locked_mask        = lk_reg;

`ifndef SYNTHESIS
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall with empty input register");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("item advanced but no result shown");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(pm_cur) && $stable(rm_cur) && $stable(pe_cur)
                      && $stable(re_cur) && $stable(lk_cur)))
        else $error("button flags changed without an item");

    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pm_reg == pm_cur && rm_reg == rm_cur && pe_reg == pe_cur
                           && re_reg == re_cur && lk_reg == lk_cur))
        else $error("result differs from button flags");
`endif

endmodule

// ----- verif/keypad_flag_checker.sv -----
`timescale 1ns / 1ps

module keypad_flag_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         func,
    input  logic [adckp_pkg::SAMPLE_W-1:0]     adc_sample,
    input  logic [adckp_pkg::BTN_W-1:0]        button,
    input  logic [adckp_pkg::FLAG_W-1:0]       flag_mask,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [adckp_pkg::NUM_BUTTONS-1:0]  pressed_mask,
    input  logic [adckp_pkg::NUM_BUTTONS-1:0]  released_mask,
    input  logic [adckp_pkg::NUM_BUTTONS-1:0]  press_event_mask,
    input  logic [adckp_pkg::NUM_BUTTONS-1:0]  release_event_mask,
    input  logic [adckp_pkg::NUM_BUTTONS-1:0]  locked_mask,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [adckp_pkg::CFG_W-1:0]        cfg_data,
    output int                                 pending,
    output int                                 fail_count
);

    typedef struct packed {
        adckp_pkg::bmask_t pressed;
        adckp_pkg::bmask_t released;
        adckp_pkg::bmask_t press_ev;
        adckp_pkg::bmask_t release_ev;
        adckp_pkg::bmask_t locked;
    } key_masks_t;

    adckp_pkg::flags_t  key_flags [adckp_pkg::NUM_BUTTONS];
    adckp_pkg::count_t  key_count [adckp_pkg::NUM_BUTTONS];
    adckp_pkg::bmask_t  scan_mask;
    adckp_pkg::count_t  press_limit;
    key_masks_t         expected_masks [$];
    key_masks_t         want;

    initial fail_count = 0;

    function automatic logic window_hit(input int b,
                                        input logic [adckp_pkg::SAMPLE_W-1:0] s);
        logic [adckp_pkg::SAMPLE_W-1:0] lo;
        logic [adckp_pkg::SAMPLE_W-1:0] hi;
        case (b)
            0:       begin lo = 8'd0;   hi = 8'd25;  end
            1:       begin lo = 8'd25;  hi = 8'd65;  end
            2:       begin lo = 8'd65;  hi = 8'd115; end
            3:       begin lo = 8'd115; hi = 8'd160; end
            4:       begin lo = 8'd165; hi = 8'd195; end
            default: begin lo = 8'd200; hi = 8'd220; end
        endcase
        return (s < hi) && ((b == 0) || (s > lo));
    endfunction

    // updates the flag and counter copy for one item, returns the masks after it
    function automatic key_masks_t apply_item(input logic [1:0] fn,
                                              input logic [adckp_pkg::SAMPLE_W-1:0] s,
                                              input logic [adckp_pkg::BTN_W-1:0] btn,
                                              input adckp_pkg::flags_t fm);
        key_masks_t        m;
        adckp_pkg::flags_t f;
        m = '0;
        case (fn)
            adckp_pkg::FUNC_TICK:
            begin
                for (int b = 0; b < adckp_pkg::NUM_BUTTONS; b++)
                begin
                    f = key_flags[b];
                    if (scan_mask[b] && !f[adckp_pkg::FLAG_LOCKED])
                    begin
                        if (!window_hit(b, s))
                        begin
                            if (key_count[b] != '0)
                                key_count[b] = key_count[b] - 1'b1;
                            else if (f[adckp_pkg::FLAG_PRESSED])
                            begin
                                f[adckp_pkg::FLAG_RELEASE_EV] = 1'b1;
                                f[adckp_pkg::FLAG_RELEASED]   = 1'b1;
                                f[adckp_pkg::FLAG_PRESSED]    = 1'b0;
                            end
                        end
                        else
                        begin
                            if (key_count[b] < press_limit)
                                key_count[b] = key_count[b] + 1'b1;
                            else if (f[adckp_pkg::FLAG_RELEASED])
                            begin
                                f[adckp_pkg::FLAG_PRESS_EV] = 1'b1;
                                f[adckp_pkg::FLAG_PRESSED]  = 1'b1;
                                f[adckp_pkg::FLAG_RELEASED] = 1'b0;
                            end
                        end
                        key_flags[b] = f;
                    end
                end
            end
            adckp_pkg::FUNC_SET:
            begin
                if (btn < adckp_pkg::NUM_BUTTONS)
                    key_flags[btn] = key_flags[btn] | fm;
            end
            adckp_pkg::FUNC_CLEAR:
            begin
                if (btn < adckp_pkg::NUM_BUTTONS)
                    key_flags[btn] = key_flags[btn] & ~fm;
            end
            default:
            begin
            end
        endcase
        for (int b = 0; b < adckp_pkg::NUM_BUTTONS; b++)
        begin
            m.pressed[b]    = key_flags[b][adckp_pkg::FLAG_PRESSED];
            m.released[b]   = key_flags[b][adckp_pkg::FLAG_RELEASED];
            m.press_ev[b]   = key_flags[b][adckp_pkg::FLAG_PRESS_EV];
            m.release_ev[b] = key_flags[b][adckp_pkg::FLAG_RELEASE_EV];
            m.locked[b]     = key_flags[b][adckp_pkg::FLAG_LOCKED];
        end
        return m;
    endfunction

    task automatic check_field(input string name, input adckp_pkg::bmask_t exp_v,
                               input adckp_pkg::bmask_t got);
        if (got !== exp_v)
        begin
            $display("%0t: %s expected %b got %b", $time, name, exp_v, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < adckp_pkg::NUM_BUTTONS; b++)
            begin
                key_flags[b] = adckp_pkg::FLAGS_RESET;
                key_count[b] = '0;
            end
            scan_mask   = adckp_pkg::SCAN_RESET;
            press_limit = adckp_pkg::LIMIT_RESET;
            expected_masks.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_masks.size() == 0)
                begin
                    $display("%0t: unexpected result pm %b rm %b pe %b re %b lk %b",
                             $time, pressed_mask, released_mask, press_event_mask,
                             release_event_mask, locked_mask);
                    fail_count++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    check_field("pressed_mask", want.pressed, pressed_mask);
                    check_field("released_mask", want.released, released_mask);
                    check_field("press_event_mask", want.press_ev, press_event_mask);
                    check_field("release_event_mask", want.release_ev, release_event_mask);
                    check_field("locked_mask", want.locked, locked_mask);
                end
            end
            if (cfg_we)
            begin
                case (adckp_pkg::cfg_idx_t'(cfg_index))
                    adckp_pkg::CFG_SCAN_ENABLE:
                        scan_mask   = cfg_data[adckp_pkg::NUM_BUTTONS-1:0];
                    adckp_pkg::CFG_DEBOUNCE:
                        press_limit = cfg_data[adckp_pkg::COUNT_W-1:0];
                endcase
            end
            if (in_valid && !in_stall)
                expected_masks.push_back(apply_item(func, adc_sample, button, flag_mask));
            pending <= expected_masks.size();
        end
    end

endmodule

// ----- verif/tb_adc_ladder_keypad_debouncer.sv -----
`timescale 1ns / 1ps

module tb_adc_ladder_keypad_debouncer;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 135;
    localparam int         NUM_PHASES = 8;
    localparam int         CYCLE_LIMIT = 400000;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [1:0]                         func = adckp_pkg::FUNC_TICK;
    logic [adckp_pkg::SAMPLE_W-1:0]     adc_sample = '0;
    logic [adckp_pkg::BTN_W-1:0]        button = '0;
    logic [adckp_pkg::FLAG_W-1:0]       flag_mask = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    adckp_pkg::bmask_t                  pressed_mask;
    adckp_pkg::bmask_t                  released_mask;
    adckp_pkg::bmask_t                  press_event_mask;
    adckp_pkg::bmask_t                  release_event_mask;
    adckp_pkg::bmask_t                  locked_mask;
    logic                               cfg_we = 1'b0;
    logic                               cfg_index = adckp_pkg::CFG_SCAN_ENABLE;
    logic [adckp_pkg::CFG_W-1:0]        cfg_data = '0;
    int                                 pending;
    int                                 fail_count;

    int items_sent = 0;
    int burst_left = 8;
    int cycles = 0;

    adc_ladder_keypad_debouncer i_dut (.*);

    keypad_flag_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_adc_ladder_keypad_debouncer: FAIL");
        $finish;
    end

    // receiver: random stall segments, now and then a long hold-off
    initial
    begin
        int seg;
        int mode;
        int len;
        seg = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            seg++;
            if (seg % 10 == 5)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(10, 120);
                repeat (len)
                begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] fn, input logic [adckp_pkg::SAMPLE_W-1:0] s,
                             input logic [adckp_pkg::BTN_W-1:0] btn,
                             input logic [adckp_pkg::FLAG_W-1:0] fm);
        int gap;
        func       <= fn;
        adc_sample <= s;
        button     <= btn;
        flag_mask  <= fm;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // tick item; button and flag mask carry noise
    task automatic send_tick(input logic [adckp_pkg::SAMPLE_W-1:0] s);
        send_item(adckp_pkg::FUNC_TICK, s, adckp_pkg::BTN_W'($urandom),
                  adckp_pkg::FLAG_W'($urandom));
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_config(input adckp_pkg::bmask_t scan, input adckp_pkg::count_t lim);
        cfg_we    <= 1'b1;
        cfg_index <= adckp_pkg::CFG_SCAN_ENABLE;
        cfg_data  <= adckp_pkg::CFG_W'(scan);
        @(posedge clk);
        cfg_index <= adckp_pkg::CFG_DEBOUNCE;
        cfg_data  <= {3'($urandom), lim};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // sample inside button b's window; b above 5 means between windows
    function automatic logic [adckp_pkg::SAMPLE_W-1:0] pick_sample(input int b);
        logic [adckp_pkg::SAMPLE_W-1:0] s;
        case (b)
            0: s = adckp_pkg::SAMPLE_W'($urandom_range(0, 24));
            1: s = adckp_pkg::SAMPLE_W'($urandom_range(26, 64));
            2: s = adckp_pkg::SAMPLE_W'($urandom_range(66, 114));
            3: s = adckp_pkg::SAMPLE_W'($urandom_range(116, 159));
            4: s = adckp_pkg::SAMPLE_W'($urandom_range(166, 194));
            5: s = adckp_pkg::SAMPLE_W'($urandom_range(201, 219));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: s = adckp_pkg::SAMPLE_W'($urandom_range(160, 165));
                    1: s = adckp_pkg::SAMPLE_W'($urandom_range(195, 200));
                    2: s = adckp_pkg::SAMPLE_W'($urandom_range(220, 255));
                    default: s = ($urandom_range(0, 1) == 0) ? 8'd25 :
                                 (($urandom_range(0, 1) == 0) ? 8'd65 : 8'd115);
                endcase
            end
        endcase
        return s;
    endfunction

    // a held key: a run of ticks in one window, or between windows, with the odd glitch
    task automatic key_hold();
        int target;
        int len;
        target = $urandom_range(0, 6);
        len = $urandom_range(1, 12);
        repeat (len)
        begin
            if ($urandom_range(0, 9) == 0)
                send_tick(adckp_pkg::SAMPLE_W'($urandom));
            else
                send_tick(pick_sample(target));
        end
    endtask

    task automatic soft_item();
        logic [adckp_pkg::FLAG_W-1:0] fm;
        fm = adckp_pkg::FLAG_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                fm[adckp_pkg::FLAG_LOCKED] = ($urandom_range(0, 3) == 0);
                send_item(adckp_pkg::FUNC_SET, adckp_pkg::SAMPLE_W'($urandom),
                          adckp_pkg::BTN_W'($urandom), fm);
            end
            4, 5, 6, 7:
                send_item(adckp_pkg::FUNC_CLEAR, adckp_pkg::SAMPLE_W'($urandom),
                          adckp_pkg::BTN_W'($urandom), fm);
            8:
                send_item(FUNC_UNUSED, adckp_pkg::SAMPLE_W'($urandom),
                          adckp_pkg::BTN_W'($urandom), fm);
            default:
                send_tick(adckp_pkg::SAMPLE_W'($urandom));
        endcase
    endtask

    initial
    begin
        logic [adckp_pkg::SAMPLE_W-1:0] sweep [18];
        adckp_pkg::bmask_t scan;
        adckp_pkg::count_t lim;
        int target;
        sweep = '{8'd0, 8'd24, 8'd25, 8'd26, 8'd64, 8'd65, 8'd114, 8'd115, 8'd159,
                  8'd160, 8'd165, 8'd166, 8'd194, 8'd195, 8'd200, 8'd219, 8'd220, 8'd255};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_config(6'h3F, 3'd1);
        foreach (sweep[i])
            send_tick(sweep[i]);
        send_item(adckp_pkg::FUNC_SET, 8'd0, 3'd0, 5'b00001);
        send_tick(8'd10);
        send_item(FUNC_UNUSED, 8'hFF, 3'd2, 5'b11111);
        send_item(adckp_pkg::FUNC_SET, 8'd0, 3'd7, 5'b11111);
        send_item(adckp_pkg::FUNC_CLEAR, 8'd0, 3'd6, 5'b11111);
        send_item(adckp_pkg::FUNC_SET, 8'd0, 3'd5, 5'b11111);
        send_item(adckp_pkg::FUNC_CLEAR, 8'd0, 3'd5, 5'b11111);
        send_item(adckp_pkg::FUNC_CLEAR, 8'd0, 3'd0, 5'b11111);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin scan = 6'h3F; lim = 3'd7; end
                1: begin scan = 6'h3F; lim = 3'd0; end
                2: begin scan = 6'h2A; lim = 3'd3; end
                3: begin scan = 6'h3F; lim = 3'd6; end
                4: begin scan = 6'h00; lim = 3'd2; end
                7: begin scan = 6'h15; lim = 3'd5; end
                default:
                begin
                    scan = adckp_pkg::NUM_BUTTONS'($urandom);
                    lim  = adckp_pkg::COUNT_W'($urandom);
                end
            endcase
            drain(4);
            write_config(scan, lim);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 3) != 0)
                    key_hold();
                else
                    soft_item();
            end
        end

        drain(10);
        if (fail_count == 0)
            $display("tb_adc_ladder_keypad_debouncer: PASS");
        else
            $display("tb_adc_ladder_keypad_debouncer: FAIL");
        $finish;
    end

endmodule

// ----- adc_ladder_keypad_debouncer.f -----
rtl/adckp_pkg.sv
rtl/adc_ladder_keypad_debouncer.sv
verif/keypad_flag_checker.sv
verif/tb_adc_ladder_keypad_debouncer.sv
